// ===== rtl/jbhe_pkg.sv =====
package jbhe_pkg;

  typedef logic [15:0] code_t;
  typedef logic [4:0]  len_t;

  localparam int unsigned BLOCK_COEFS = 64;
  localparam int unsigned POS_W       = $clog2(BLOCK_COEFS);

  // Escape for a run of fifteen zeros, and the end-of-block code
  localparam code_t       ESC_CODE       = 16'hFF7;
  localparam len_t        ESC_LEN        = 5'd12;
  localparam code_t       EOB_CODE       = 16'hA;
  localparam len_t        EOB_LEN        = 5'd4;
  localparam logic [3:0]  ZERO_RUN_LIMIT = 4'd15;

  // Saturation limits for the DC difference and the AC values
  localparam logic signed [12:0] DC_LIM = 13'sd2047;
  localparam logic signed [12:0] AC_LIM = 13'sd1023;

  // DC size-category codes
  localparam code_t DC_CODE [12] = '{
    16'h2, 16'h3, 16'h4, 16'h0, 16'h5, 16'h6, 16'hE, 16'h1E, 16'h3E, 16'h7E, 16'hFE, 16'h1FE
  };
  localparam len_t DC_LEN [12] = '{
    5'd3, 5'd3, 5'd3, 5'd2, 5'd3, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9
  };

  // AC run/size codes, row is run, column is size - 1
  localparam code_t AC_CODE [16][10] = '{
    '{16'h0, 16'h1, 16'h4, 16'hB, 16'h1A, 16'h38, 16'h78, 16'h3F6, 16'hFF82, 16'hFF83},
    '{16'hC, 16'h39, 16'h79, 16'h1F6, 16'h7F6, 16'hFF84, 16'hFF85, 16'hFF86, 16'hFF87,
      16'hFF88},
    '{16'h1B, 16'hF8, 16'h3F7, 16'hFF89, 16'hFF8A, 16'hFF8B, 16'hFF8C, 16'hFF8D, 16'hFF8E,
      16'hFF8F},
    '{16'h3A, 16'h1F7, 16'h7F7, 16'hFF90, 16'hFF91, 16'hFF92, 16'hFF93, 16'hFF94, 16'hFF95,
      16'hFF96},
    '{16'h3B, 16'h3F8, 16'hFF97, 16'hFF98, 16'hFF99, 16'hFF9A, 16'hFF9B, 16'hFF9C, 16'hFF9D,
      16'hFF9E},
    '{16'h7A, 16'h3F9, 16'hFF9F, 16'hFFA0, 16'hFFA1, 16'hFFA2, 16'hFFA3, 16'hFFA4, 16'hFFA5,
      16'hFFA6},
    '{16'h7B, 16'h7F8, 16'hFFA7, 16'hFFA8, 16'hFFA9, 16'hFFAA, 16'hFFAB, 16'hFFAC, 16'hFFAD,
      16'hFFAE},
    '{16'hF9, 16'h7F9, 16'hFFAF, 16'hFFB0, 16'hFFB1, 16'hFFB2, 16'hFFB3, 16'hFFB4, 16'hFFB5,
      16'hFFB6},
    '{16'hFA, 16'h7FC0, 16'hFFB7, 16'hFFB8, 16'hFFB9, 16'hFFBA, 16'hFFBB, 16'hFFBC, 16'hFFBD,
      16'hFFBE},
    '{16'h1F8, 16'hFFBF, 16'hFFC0, 16'hFFC1, 16'hFFC2, 16'hFFC3, 16'hFFC4, 16'hFFC5, 16'hFFC6,
      16'hFFC7},
    '{16'h1F9, 16'hFFC8, 16'hFFC9, 16'hFFCA, 16'hFFCB, 16'hFFCC, 16'hFFCD, 16'hFFCE, 16'hFFCF,
      16'hFFD0},
    '{16'h1FA, 16'hFFD1, 16'hFFD2, 16'hFFD3, 16'hFFD4, 16'hFFD5, 16'hFFD6, 16'hFFD7, 16'hFFD8,
      16'hFFD9},
    '{16'h3FA, 16'hFFDA, 16'hFFDB, 16'hFFDC, 16'hFFDD, 16'hFFDE, 16'hFFDF, 16'hFFE0, 16'hFFE1,
      16'hFFE2},
    '{16'h7FA, 16'hFFE3, 16'hFFE4, 16'hFFE5, 16'hFFE6, 16'hFFE7, 16'hFFE8, 16'hFFE9, 16'hFFEA,
      16'hFFEB},
    '{16'hFF6, 16'hFFEC, 16'hFFED, 16'hFFEE, 16'hFFEF, 16'hFFF0, 16'hFFF1, 16'hFFF2, 16'hFFF3,
      16'hFFF4},
    '{16'hFFF5, 16'hFFF6, 16'hFFF7, 16'hFFF8, 16'hFFF9, 16'hFFFA, 16'hFFFB, 16'hFFFC, 16'hFFFD,
      16'hFFFE}
  };

  localparam len_t AC_LEN [16][10] = '{
    '{5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10, 5'd16, 5'd16},
    '{5'd4, 5'd6, 5'd7, 5'd9, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd5, 5'd8, 5'd10, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd6, 5'd9, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd6, 5'd10, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd7, 5'd10, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd7, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd8, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd8, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd9, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd9, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd9, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd10, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd11, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd12, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16}
  };

endpackage

// ===== rtl/jpeg_block_huffman_encoder_core.sv =====
// Steps: a zero AC item passes idle and prep; a coded item passes idle, prep, one step
// per pending escape, run/size code and magnitude, plus one drain per byte (up to 2 per
// field), longer while out_ready is low. The last position adds the end code and pad byte.
// Throughput: one item at a time, set by the single shared bit packer (append or drain).
// Reset: rst_n synchronous, active low; clears position, zero run, pending escapes,
// the bit accumulator, the sequencer and the output valid.
module jpeg_block_huffman_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [11:0] in_coef,
  input  logic signed [11:0] in_predictor,
  input  logic               in_predictor_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_block_end
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ESC  = 3'd2;
  localparam logic [2:0] S_CODE = 3'd3;
  localparam logic [2:0] S_MAG  = 3'd4;
  localparam logic [2:0] S_EOB  = 3'd5;
  localparam logic [2:0] S_PAD  = 3'd6;

  localparam int unsigned POS_W = jbhe_pkg::POS_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(jbhe_pkg::BLOCK_COEFS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [POS_W-1:0]  position_r, position_nxt;
  logic [3:0]        zero_run_r, zero_run_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic signed [12:0] val_r, val_nxt;
  logic [3:0]        cat_r, cat_nxt;
  logic [10:0]       mag_r, mag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_block_end_r, out_block_end_nxt;

  logic               is_dc, is_last, out_free, drain_go, app_go, pad_go;
  logic signed [12:0] lim, vc;
  logic [11:0]        v12, u12;
  logic [10:0]        absv, mask;
  logic [3:0]         cat_c, ac_col;
  jbhe_pkg::code_t    fld, fld_al;
  jbhe_pkg::len_t     len;

  assign is_dc    = (position_r == '0);
  assign is_last  = (position_r == LAST_POS);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_block_end = out_block_end_r;

  // Saturation, size category and magnitude bits of the held value
  always_comb begin
    lim = is_dc ? jbhe_pkg::DC_LIM : jbhe_pkg::AC_LIM;
    if (val_r > lim) begin
      vc = lim;
    end else if (val_r < -lim) begin
      vc = -lim;
    end else begin
      vc = val_r;
    end
    v12  = vc[11:0];
    absv = v12[11] ? 11'(-v12) : v12[10:0];
    cat_c = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (absv[i]) cat_c = 4'(i + 1);
    end
    u12  = v12[11] ? (v12 - 12'd1) : v12;
    mask = ~(11'h7FF << cat_c);
  end

  // Field selection for the shared packer
  assign ac_col = cat_r - 4'd1;
  always_comb begin
    unique case (state_r)
      S_ESC: begin
        fld = jbhe_pkg::ESC_CODE;
        len = jbhe_pkg::ESC_LEN;
      end
      S_CODE: begin
        fld = is_dc ? jbhe_pkg::DC_CODE[cat_r] : jbhe_pkg::AC_CODE[zero_run_r][ac_col];
        len = is_dc ? jbhe_pkg::DC_LEN[cat_r]  : jbhe_pkg::AC_LEN[zero_run_r][ac_col];
      end
      S_MAG: begin
        fld = {5'd0, mag_r};
        len = {1'b0, cat_r};
      end
      S_EOB: begin
        fld = jbhe_pkg::EOB_CODE;
        len = jbhe_pkg::EOB_LEN;
      end
      default: begin
        fld = '0;
        len = '0;
      end
    endcase
    fld_al = fld << (5'd16 - len);
  end

  // Shared packer: drain a byte when eight bits are held, else append a field
  assign drain_go = (cnt_r >= 5'd8) && out_free;
  assign app_go   = (cnt_r < 5'd8) && ((state_r == S_ESC) || (state_r == S_CODE) ||
                                       (state_r == S_MAG) || (state_r == S_EOB));
  assign pad_go   = (cnt_r < 5'd8) && (state_r == S_PAD) && out_free;

  always_comb begin
    state_nxt         = state_r;
    position_nxt      = position_r;
    zero_run_nxt      = zero_run_r;
    pend_nxt          = pend_r;
    acc_nxt           = acc_r;
    cnt_nxt           = cnt_r;
    val_nxt           = val_r;
    cat_nxt           = cat_r;
    mag_nxt           = mag_r;
    out_valid_nxt     = out_valid_r;
    out_byte_nxt      = out_byte_r;
    out_block_end_nxt = out_block_end_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (drain_go) begin
      out_valid_nxt     = 1'b1;
      out_byte_nxt      = acc_r[23:16];
      out_block_end_nxt = 1'b0;
      acc_nxt           = acc_r << 8;
      cnt_nxt           = cnt_r - 5'd8;
    end else if (app_go) begin
      acc_nxt = acc_r | ({fld_al, 8'h00} >> cnt_r);
      cnt_nxt = cnt_r + len;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_dc && in_predictor_valid) begin
            val_nxt = 13'(in_predictor) - 13'(in_coef);
          end else begin
            val_nxt = 13'(in_coef);
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cat_nxt = cat_c;
        mag_nxt = u12[10:0] & mask;
        if (is_dc) begin
          zero_run_nxt = '0;
          pend_nxt     = '0;
          state_nxt    = S_CODE;
        end else if (val_r == '0) begin
          // zero AC: extend the run, turning fifteen zeros into a pending escape
          if (zero_run_r + 4'd1 >= jbhe_pkg::ZERO_RUN_LIMIT) begin
            zero_run_nxt = '0;
            pend_nxt     = pend_r + 3'd1;
          end else begin
            zero_run_nxt = zero_run_r + 4'd1;
          end
          if (is_last) begin
            state_nxt = S_EOB;
          end else begin
            position_nxt = position_r + POS_W'(1);
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = (pend_r != '0) ? S_ESC : S_CODE;
        end
      end
      S_ESC: begin
        if (app_go) begin
          pend_nxt = pend_r - 3'd1;
          if (pend_r == 3'd1) state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        if (app_go) state_nxt = S_MAG;
      end
      S_MAG: begin
        if (app_go) begin
          zero_run_nxt = '0;
          if (is_last) begin
            state_nxt = S_EOB;
          end else begin
            position_nxt = position_r + POS_W'(1);
            state_nxt    = S_IDLE;
          end
        end
      end
      S_EOB: begin
        if (app_go) state_nxt = S_PAD;
      end
      S_PAD: begin
        // final byte padded with ones; block state cleared
        if (pad_go) begin
          out_valid_nxt     = 1'b1;
          out_byte_nxt      = acc_r[23:16] | (8'hFF >> cnt_r[2:0]);
          out_block_end_nxt = 1'b1;
          acc_nxt           = '0;
          cnt_nxt           = '0;
          position_nxt      = '0;
          zero_run_nxt      = '0;
          pend_nxt          = '0;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      position_r  <= '0;
      zero_run_r  <= '0;
      pend_r      <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      zero_run_r  <= zero_run_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    val_r           <= val_nxt;
    cat_r           <= cat_nxt;
    mag_r           <= mag_nxt;
    out_byte_r      <= out_byte_nxt;
    out_block_end_r <= out_block_end_nxt;
  end

  // Checks
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd23)
    else $error("bit count beyond the accumulator");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("pending escape count out of range");

  a_esc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ESC) |-> (pend_r != '0))
    else $error("escape state with no pending escape");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r < jbhe_pkg::ZERO_RUN_LIMIT)
    else $error("zero run reached the escape limit");

  a_pad_end: assert property (@(posedge clk) disable iff (!rst_n)
    pad_go |=> (out_valid_r && out_block_end_r && position_r == '0))
    else $error("pad byte not presented as block end");

endmodule

// ===== tb/tb.sv =====
module tb;

  // Coded byte as it leaves the encoder
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_byte_t;

  // One row of directed stimulus: an item repeated reps times. Where typed_n is not
  // TYPED_NONE, the row's final item must yield exactly the typed bytes.
  typedef struct packed {
    logic signed [11:0] coef;
    logic signed [11:0] pred;
    logic               pred_ok;
    int                 reps;
    int                 typed_n;
    logic [7:0]         typed0;
    logic [7:0]         typed1;
    logic               typed_last;
  } dir_row_t;

  localparam int TYPED_NONE = -1;
  localparam int COEFS_PER_BLOCK = 64;
  localparam int LAST_POS = COEFS_PER_BLOCK - 1;
  localparam int RANDOM_BLOCKS = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 40;

  localparam logic [15:0] ZRL_ESCAPE = 16'hFF7;
  localparam int unsigned ZRL_ESCAPE_LEN = 12;
  localparam logic [15:0] END_OF_BLOCK = 16'hA;
  localparam int unsigned END_OF_BLOCK_LEN = 4;
  localparam logic [15:0] FIRST_LONG_CODE = 16'hFF82;

  // DC size-category codes
  localparam logic [15:0] DC_HUFF [12] = '{
    16'h2, 16'h3, 16'h4, 16'h0, 16'h5, 16'h6, 16'hE, 16'h1E, 16'h3E, 16'h7E, 16'hFE, 16'h1FE
  };
  localparam int unsigned DC_HUFF_LEN [12] = '{3, 3, 3, 2, 3, 3, 4, 5, 6, 7, 8, 9};

  // AC codes shorter than 16 bits, row by row; the 16-bit ones count up from FIRST_LONG_CODE
  localparam int unsigned AC_SHORT_PER_RUN [16] = '{8, 5, 3, 3, 2, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1, 0};
  localparam logic [15:0] AC_SHORT [35] = '{
    16'h0, 16'h1, 16'h4, 16'hB, 16'h1A, 16'h38, 16'h78, 16'h3F6,
    16'hC, 16'h39, 16'h79, 16'h1F6, 16'h7F6,
    16'h1B, 16'hF8, 16'h3F7,
    16'h3A, 16'h1F7, 16'h7F7,
    16'h3B, 16'h3F8,
    16'h7A, 16'h3F9,
    16'h7B, 16'h7F8,
    16'hF9, 16'h7F9,
    16'hFA, 16'h7FC0,
    16'h1F8, 16'h1F9, 16'h1FA, 16'h3FA, 16'h7FA, 16'hFF6
  };
  localparam int unsigned AC_SHORT_LEN [35] = '{
    2, 2, 3, 4, 5, 6, 7, 10,
    4, 6, 7, 9, 11,
    5, 8, 10,
    6, 9, 11,
    6, 10,
    7, 10,
    7, 11,
    8, 11,
    8, 15,
    9, 9, 9, 10, 11, 12
  };

  // Directed blocks: zero DC difference ending on four discarded escapes, saturated DC
  // with aligned end, and a mixed block with escapes and AC saturation
  localparam dir_row_t DIRECTED [15] = '{
    '{12'sd100, 12'sd100, 1'b1, 1, 0, 8'h00, 8'h00, 1'b0},
    '{12'sd0, 12'sd0, 1'b0, 63, 1, 8'h55, 8'h00, 1'b1},
    '{-12'sd2047, 12'sd2047, 1'b1, 1, 2, 8'hFF, 8'h7F, 1'b0},
    '{12'sd0, 12'sd0, 1'b0, 63, 2, 8'hFA, 8'hFF, 1'b1},
    '{12'sh800, 12'sd2047, 1'b1, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd0, 12'sh800, 1'b1, 5, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd5, -12'sd5, 1'b1, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd0, 12'sd0, 1'b0, 33, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd2047, 12'sd0, 1'b0, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sh800, 12'sd0, 1'b0, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd1, 12'sd0, 1'b0, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{-12'sd1, 12'sd0, 1'b0, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd0, -12'sd1, 1'b1, 16, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{-12'sd700, 12'sd0, 1'b0, 1, TYPED_NONE, 8'h00, 8'h00, 1'b0},
    '{12'sd0, 12'sd0, 1'b0, 3, TYPED_NONE, 8'h00, 8'h00, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [11:0] in_coef = '0;
  logic signed [11:0] in_predictor = '0;
  logic               in_predictor_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               out_block_end;

  // Encoder state as predicted
  logic [5:0] enc_pos;
  logic [3:0] enc_zrun;
  logic [2:0] enc_esc;
  logic [7:0] enc_buf;
  logic [2:0] enc_fill;

  logic [15:0]  ac_huff [16][10];
  int unsigned  ac_huff_len [16][10];

  coded_byte_t step_bytes [$];
  coded_byte_t coded_bytes [$];

  int mismatches = 0;
  int bytes_checked = 0;
  int blocks_seen = 0;
  int coefs_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  logic [9:0] stall_phase = '0;

  jpeg_block_huffman_encoder_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_coef            (in_coef),
    .in_predictor       (in_predictor),
    .in_predictor_valid (in_predictor_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_block_end      (out_block_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Expand the short list into the full run/size table
  function automatic void build_ac_table();
    int unsigned k;
    logic [15:0] next_long;
    k = 0;
    next_long = FIRST_LONG_CODE;
    for (int run = 0; run < 16; run++) begin
      for (int sz = 0; sz < 10; sz++) begin
        if (sz < AC_SHORT_PER_RUN[run]) begin
          ac_huff[run][sz] = AC_SHORT[k];
          ac_huff_len[run][sz] = AC_SHORT_LEN[k];
          k++;
        end else begin
          ac_huff[run][sz] = next_long;
          ac_huff_len[run][sz] = 16;
          next_long++;
        end
      end
    end
  endfunction

  function automatic void clear_encoder();
    enc_pos = '0;
    enc_zrun = '0;
    enc_esc = '0;
    enc_buf = '0;
    enc_fill = '0;
  endfunction

  function automatic int clip(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int unsigned size_cat(input int v);
    int unsigned m;
    int unsigned c;
    m = (v < 0) ? -v : v;
    c = 0;
    while (m != 0) begin
      c++;
      m >>= 1;
    end
    return c;
  endfunction

  // Low cat bits of v, or of v - 1 for negatives
  function automatic logic [15:0] mag_field(input int v, input int unsigned cat);
    int u;
    u = (v < 0) ? v - 1 : v;
    return 16'(u) & 16'((1 << cat) - 1);
  endfunction

  // MSB-first bit packer; each full byte goes to step_bytes
  function automatic void pack_bits(input logic [15:0] code, input int unsigned len);
    for (int i = int'(len) - 1; i >= 0; i--) begin
      enc_buf[7 - enc_fill] = code[i];
      if (enc_fill == 3'd7) begin
        step_bytes.push_back('{enc_buf, 1'b0});
        enc_buf = '0;
        enc_fill = '0;
      end else begin
        enc_fill++;
      end
    end
  endfunction

  // Bytes produced by one coefficient item
  function automatic void huff_encode(input logic signed [11:0] coef,
                                      input logic signed [11:0] pred, input logic pred_ok);
    int diff;
    int unsigned cat;
    step_bytes.delete();
    if (enc_pos == 0) begin
      diff = pred_ok ? int'(pred) - int'(coef) : int'(coef);
      diff = clip(diff, 2047);
      cat = size_cat(diff);
      pack_bits(DC_HUFF[cat], DC_HUFF_LEN[cat]);
      pack_bits(mag_field(diff, cat), cat);
      enc_zrun = '0;
      enc_esc = '0;
    end else if (coef == 0) begin
      // fifteen zeros become one deferred escape
      if (enc_zrun == 4'd14) begin
        enc_zrun = '0;
        enc_esc++;
      end else begin
        enc_zrun++;
      end
    end else begin
      diff = clip(int'(coef), 1023);
      cat = size_cat(diff);
      while (enc_esc != 0) begin
        pack_bits(ZRL_ESCAPE, ZRL_ESCAPE_LEN);
        enc_esc--;
      end
      pack_bits(ac_huff[enc_zrun][cat - 1], ac_huff_len[enc_zrun][cat - 1]);
      pack_bits(mag_field(diff, cat), cat);
      enc_zrun = '0;
    end
    // end of block: trailing zeros dropped, code and pad with ones
    if (enc_pos == 6'(LAST_POS)) begin
      pack_bits(END_OF_BLOCK, END_OF_BLOCK_LEN);
      step_bytes.push_back('{enc_buf | (8'hFF >> enc_fill), 1'b1});
      clear_encoder();
    end else begin
      enc_pos++;
    end
  endfunction

  function automatic void queue_step();
    foreach (step_bytes[i]) coded_bytes.push_back(step_bytes[i]);
  endfunction

  // Offer one item in bursts with random gaps; predict on acceptance
  task automatic send_coef(input logic signed [11:0] coef, input logic signed [11:0] pred,
                           input logic pred_ok);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_coef <= coef;
    in_predictor <= pred;
    in_predictor_valid <= pred_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    coefs_sent++;
    huff_encode(coef, pred, pred_ok);
  endtask

  // Random AC value: zero with the given odds, sometimes -2048, else small sizes favoured
  function automatic logic signed [11:0] pick_ac(input int zero_pct);
    int unsigned cat;
    int unsigned mag;
    logic signed [11:0] v;
    if ($urandom_range(0, 99) < zero_pct) return '0;
    if ($urandom_range(0, 19) == 0) return 12'sh800;
    cat = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : $urandom_range(1, 4);
    mag = $urandom_range((1 << cat) - 1, 1 << (cat - 1));
    v = 12'(mag);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Receiver: ready always, at random, one in four, or long stalls
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_ready <= (stall_phase[1:0] == 2'd0);
      end
      default: begin
        out_ready <= (stall_phase[4:0] >= 5'd24);
      end
    endcase
  end

  // Compare every accepted byte with the oldest prediction
  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (out_block_end) blocks_seen++;
      if (coded_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h end %0b with none predicted",
                                  out_byte, out_block_end));
      end else begin
        want = coded_bytes.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %02h, predicted %02h", out_byte, want.data));
        if (out_block_end !== want.last)
          report_mismatch($sformatf("block_end %0b, predicted %0b on byte %02h",
                                    out_block_end, want.last, want.data));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d bytes outstanding",
             coded_bytes.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    dir_row_t row;
    int zero_pct;
    build_ac_table();
    clear_encoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed blocks
    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int k = 0; k < row.reps; k++) begin
        send_coef(row.coef, row.pred, row.pred_ok);
        if (row.typed_n == TYPED_NONE || k != row.reps - 1) begin
          queue_step();
        end else begin
          if (row.typed_n >= 1) coded_bytes.push_back('{row.typed0, row.typed_n == 1 &&
                                                         row.typed_last});
          if (row.typed_n == 2) coded_bytes.push_back('{row.typed1, row.typed_last});
        end
      end
    end

    // Random blocks: zero odds 20, 60, then 90 percent; RANDOM_BLOCKS is 1, so only 20 percent
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      zero_pct = (b == 0) ? 20 : (b == 1) ? 60 : 90;
      send_coef(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                1'($urandom_range(0, 1)));
      queue_step();
      for (int p = 1; p < COEFS_PER_BLOCK; p++) begin
        send_coef(pick_ac(zero_pct), 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
        queue_step();
      end
    end
    in_valid <= 1'b0;

    while (coded_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d coefficients in %0d blocks; %0d bytes checked, %0d block ends.",
             coefs_sent, coefs_sent / COEFS_PER_BLOCK, bytes_checked, blocks_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== jpeg_block_huffman_encoder_core.f =====
rtl/jbhe_pkg.sv
rtl/jpeg_block_huffman_encoder_core.sv
tb/tb.sv
